[sv/tlbpt_pkg.sv]
// Shared types and constants for the TLB / page table translator.
// No dependencies; the top level and the testbench refer to it by scoped names.
package tlbpt_pkg;

  // Fixed field widths of the address channels.
  localparam int VA_W = 16;
  localparam int PA_W = 16;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_WALK   = 4'b1000
  } state_t;

endpackage

[sv/tlbpt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

[sv/tlbpt_cell.sv]
// One TLB slot of the FIFO shift chain: holds a tag, a frame and a valid bit.
// No dependencies; instantiated in a row by the top level.
module tlbpt_cell #(
  parameter int TAG_W   = 8,
  parameter int FRAME_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift_en,
  input  logic               prev_valid,
  input  logic [TAG_W-1:0]   prev_tag,
  input  logic [FRAME_W-1:0] prev_frame,
  input  logic [TAG_W-1:0]   lookup_tag,
  output logic               valid,
  output logic [TAG_W-1:0]   tag,
  output logic [FRAME_W-1:0] frame,
  output logic               match
);

  logic               valid_r;
  logic [TAG_W-1:0]   tag_r;
  logic [FRAME_W-1:0] frame_r;

  // Take the neighbor's entry on an insert; the last cell's entry drops off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      tag_r   <= prev_tag;
      frame_r <= prev_frame;
    end
  end

  assign valid = valid_r;
  assign tag   = tag_r;
  assign frame = frame_r;
  assign match = valid_r && (tag_r == lookup_tag);

endmodule

[sv/tlbpt_page_table_translator_unit.sv]
// Top level of the translator: input modulo stage, TLB cell chain, page table RAM.
// Depends on tlbpt_pkg, tlbpt_cell and tlbpt_ram.
//
// Translates a 16-bit virtual address into a 16-bit physical address, one
// transfer at a time. The page number (bits above OFFSET_BITS, reduced
// modulo PAGE_COUNT) is searched in a fully associative TLB built as a row of
// TLB_ENTRIES cells. The row is a shift chain: a miss pushes the new
// page/frame pair into the first cell and every cell hands its entry to its
// neighbor, so the oldest entry falls out of the last cell (FIFO
// replacement). On a miss the page table RAM (one valid bit plus frame per
// page) is read; an invalid entry raises page_fault, takes the next frame in
// sequence and is written back. A TLB hit passes through the accept cycle in
// IDLE, then the cell compare in LOOKUP, where the result register loads.
// A miss goes on from LOOKUP to WALK, the extra state being the registered
// read of the page table RAM, and loads the result from WALK. While the
// output register holds a result that is not taken, a hitting lookup or
// the walk holds until the result is taken. The next input is taken while a
// result still waits in the output register. After reset the block sweeps
// the page table to clear its valid bits, one entry per cycle, with in_ready
// low throughout.
module tlb_page_table_translator_unit #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int OFFSET_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tlbpt_pkg::VA_W-1:0]   in_virtual_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tlbpt_pkg::PA_W-1:0]   out_phys_addr,
  output logic                         out_tlb_hit,
  output logic                         out_page_fault
);

  // Page number and frame number share one width: frames never run past pages.
  localparam int PG_W    = $clog2(PAGE_COUNT);
  localparam int FRAME_W = PG_W;
  localparam int VPN_W   = (OFFSET_BITS < tlbpt_pkg::VA_W) ?
                           (tlbpt_pkg::VA_W - OFFSET_BITS) : 1;
  localparam int MOD_W   = VPN_W + 1;
  // Quotient bits of vpn / PAGE_COUNT: one compare-subtract step each.
  localparam int QSTEPS  = (VPN_W >= PG_W) ? (VPN_W - PG_W + 1) : 1;
  localparam int PTE_W   = FRAME_W + 1;

  tlbpt_pkg::state_t state_r, state_nxt;

  logic [PG_W-1:0]        page_r;
  logic [OFFSET_BITS-1:0] offset_r;
  logic [PG_W-1:0]        clr_cnt_r;
  logic [FRAME_W-1:0]     free_cnt_r;

  logic                   out_valid_r;
  logic [tlbpt_pkg::PA_W-1:0] out_pa_r;
  logic                   out_hit_r;
  logic                   out_fault_r;

  // ---------------------------------------------------------------------
  // Input: split the address and reduce the page number modulo PAGE_COUNT.
  // ---------------------------------------------------------------------
  logic [31:0]      va_shifted;
  logic [MOD_W-1:0] rem;
  logic [PG_W-1:0]  in_page;

  always_comb begin
    va_shifted = 32'(in_virtual_address) >> OFFSET_BITS;
    rem        = MOD_W'(va_shifted[VPN_W-1:0]);
    for (int k = QSTEPS - 1; k >= 0; k--) begin
      if (33'(rem) >= (33'(PAGE_COUNT) << k)) begin
        rem = rem - MOD_W'(33'(PAGE_COUNT) << k);
      end
    end
    in_page = PG_W'(rem);
  end

  // ---------------------------------------------------------------------
  // Handshake and sequencing.
  // ---------------------------------------------------------------------
  logic in_xfer;
  logic out_free;
  logic tlb_hit;
  logic walk_done;
  logic lookup_done;

  assign in_ready    = (state_r == tlbpt_pkg::ST_IDLE);
  assign in_xfer     = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign lookup_done = (state_r == tlbpt_pkg::ST_LOOKUP) && tlb_hit && out_free;
  assign walk_done   = (state_r == tlbpt_pkg::ST_WALK) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlbpt_pkg::ST_CLEAR: begin
        if (clr_cnt_r == PG_W'(PAGE_COUNT - 1)) begin
          state_nxt = tlbpt_pkg::ST_IDLE;
        end
      end
      tlbpt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = tlbpt_pkg::ST_LOOKUP;
        end
      end
      tlbpt_pkg::ST_LOOKUP: begin
        // Hold on a hit until the output register frees up.
        if (!tlb_hit) begin
          state_nxt = tlbpt_pkg::ST_WALK;
        end else if (out_free) begin
          state_nxt = tlbpt_pkg::ST_IDLE;
        end
      end
      tlbpt_pkg::ST_WALK: begin
        if (out_free) begin
          state_nxt = tlbpt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tlbpt_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tlbpt_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tlbpt_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + PG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      page_r   <= in_page;
      offset_r <= in_virtual_address[OFFSET_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Page table RAM: {valid, frame} per page.
  // ---------------------------------------------------------------------
  logic              pt_we;
  logic [PG_W-1:0]   pt_waddr;
  logic [PTE_W-1:0]  pt_wdata;
  logic [PTE_W-1:0]  pt_rdata;
  logic              pte_valid;
  logic [FRAME_W-1:0] pte_frame;
  logic              fault;

  assign pte_valid = pt_rdata[PTE_W-1];
  assign pte_frame = pt_rdata[FRAME_W-1:0];
  assign fault     = !pte_valid;

  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = page_r;
    pt_wdata = {1'b1, free_cnt_r};
    if (state_r == tlbpt_pkg::ST_CLEAR) begin
      // Sweep: drop every valid bit.
      pt_we    = 1'b1;
      pt_waddr = clr_cnt_r;
      pt_wdata = '0;
    end else if (walk_done && fault) begin
      // Record the freshly allocated frame.
      pt_we = 1'b1;
    end
  end

  tlbpt_ram #(
    .WIDTH (PTE_W),
    .DEPTH (PAGE_COUNT)
  ) u_page_table (
    .clk     (clk),
    .we      (pt_we),
    .waddr   (pt_waddr),
    .wdata   (pt_wdata),
    .raddr   (page_r),
    .rdata_r (pt_rdata)
  );

  // Advance the free frame counter on every fault.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_cnt_r <= '0;
    end else if (walk_done && fault) begin
      free_cnt_r <= free_cnt_r + FRAME_W'(1);
    end
  end

  // ---------------------------------------------------------------------
  // TLB: row of cells, shifted once per miss.
  // ---------------------------------------------------------------------
  logic [FRAME_W-1:0] walk_frame;
  logic               tlb_shift;
  logic               cell_valid [TLB_ENTRIES];
  logic [PG_W-1:0]    cell_tag   [TLB_ENTRIES];
  logic [FRAME_W-1:0] cell_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] cell_match;

  assign walk_frame = pte_valid ? pte_frame : free_cnt_r;
  assign tlb_shift  = walk_done;

  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      tlbpt_cell #(
        .TAG_W   (PG_W),
        .FRAME_W (FRAME_W)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (tlb_shift),
        .prev_valid (1'b1),
        .prev_tag   (page_r),
        .prev_frame (walk_frame),
        .lookup_tag (page_r),
        .valid      (cell_valid[i]),
        .tag        (cell_tag[i]),
        .frame      (cell_frame[i]),
        .match      (cell_match[i])
      );
    end else begin : g_body
      tlbpt_cell #(
        .TAG_W   (PG_W),
        .FRAME_W (FRAME_W)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (tlb_shift),
        .prev_valid (cell_valid[i-1]),
        .prev_tag   (cell_tag[i-1]),
        .prev_frame (cell_frame[i-1]),
        .lookup_tag (page_r),
        .valid      (cell_valid[i]),
        .tag        (cell_tag[i]),
        .frame      (cell_frame[i]),
        .match      (cell_match[i])
      );
    end
  end

  // At most one cell matches (pages enter only on a miss), so AND-OR select.
  logic [FRAME_W-1:0] hit_frame;

  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      hit_frame = hit_frame | (cell_frame[i] & {FRAME_W{cell_match[i]}});
    end
  end

  assign tlb_hit = |cell_match;

  // ---------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------
  logic [FRAME_W-1:0] res_frame;
  logic [31:0]        pa_wide;
  logic               res_load;

  assign res_frame = (state_r == tlbpt_pkg::ST_LOOKUP) ? hit_frame : walk_frame;
  assign pa_wide   = (32'(res_frame) << OFFSET_BITS) | 32'(offset_r);
  assign res_load  = lookup_done || walk_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_pa_r    <= pa_wide[tlbpt_pkg::PA_W-1:0];
      out_hit_r   <= lookup_done;
      out_fault_r <= walk_done && fault;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_phys_addr  = out_pa_r;
  assign out_tlb_hit    = out_hit_r;
  assign out_page_fault = out_fault_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tlbpt_pkg::ST_LOOKUP) |-> $onehot0(cell_match))
    else $error("more than one TLB cell matches the page");

  a_hit_xor_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_fault_r))
    else $error("result flags both hit and fault");

  a_fault_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (walk_done && fault) |=> (free_cnt_r == $past(free_cnt_r) + FRAME_W'(1)))
    else $error("fault did not advance the free frame counter");

  a_miss_shifts_in: assert property (@(posedge clk) disable iff (!rst_n)
    walk_done |=> (cell_valid[0] && (cell_tag[0] == $past(page_r))))
    else $error("missed page was not pushed into the head TLB cell");

endmodule

[sim/testbench.sv]
// Self-checking testbench for tlb_page_table_translator_unit: a clocked driver and monitor
// around the block, with a built-in translation predictor and a queue of expected results.
// Depends on the RTL top level (and through it tlbpt_pkg); reads no files.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Geometry of the block as instantiated (its default parameters).
  localparam int TLB_SLOTS  = 16;
  localparam int PAGE_TOTAL = 256;
  localparam int OFS_BITS   = 8;
  localparam int HOT_PAGES  = 24;
  localparam int RANDOM_PER_PHASE = 300;

  // Idling schedule: which side stalls how often.
  typedef enum logic [1:0] {
    PH_SLOW_RECEIVER,
    PH_SLOW_SENDER,
    PH_FREE_RUN
  } phase_t;

  typedef struct packed {
    logic [tlbpt_pkg::VA_W-1:0] address;
    phase_t                     phase;
  } request_t;

  typedef struct packed {
    logic [tlbpt_pkg::PA_W-1:0] physical;
    logic                       hit;
    logic                       fault;
  } translation_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [tlbpt_pkg::VA_W-1:0] in_virtual_address = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [tlbpt_pkg::PA_W-1:0] out_phys_addr;
  logic                       out_tlb_hit;
  logic                       out_page_fault;

  request_t     pending_q[$];
  translation_t expected_q[$];
  phase_t       active_phase = PH_SLOW_RECEIVER;
  int           error_count = 0;

  // Predictor state: a FIFO TLB and a page table with a sequential frame allocator.
  logic [7:0] tlb_tag   [TLB_SLOTS];
  logic [7:0] tlb_frame [TLB_SLOTS];
  logic       tlb_live  [TLB_SLOTS] = '{default: 1'b0};
  logic [3:0] fifo_slot = '0;
  logic       pt_valid  [PAGE_TOTAL] = '{default: 1'b0};
  logic [7:0] pt_frame  [PAGE_TOTAL];
  logic [8:0] next_frame = '0;

  tlb_page_table_translator_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_virtual_address (in_virtual_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_phys_addr      (out_phys_addr),
    .out_tlb_hit        (out_tlb_hit),
    .out_page_fault     (out_page_fault)
  );

  always #5 clk = ~clk;

  // Translate one address and advance the predictor state exactly as the block does:
  // a TLB hit changes nothing, a miss consults the page table (allocating a frame on
  // a fault) and pushes the page/frame pair into the next FIFO slot.
  function automatic translation_t translate_address(input logic [tlbpt_pkg::VA_W-1:0] va);
    logic [7:0]   page;
    logic [7:0]   offset;
    logic [7:0]   frame;
    logic         hit;
    logic         fault;
    translation_t result;
    page   = 8'((va >> OFS_BITS) % PAGE_TOTAL);
    offset = va[OFS_BITS-1:0];
    frame  = '0;
    hit    = 1'b0;
    fault  = 1'b0;
    // Lowest matching slot wins; duplicates cannot arise anyway.
    for (int i = 0; i < TLB_SLOTS; i++) begin
      if (!hit && tlb_live[i] && tlb_tag[i] == page) begin
        hit   = 1'b1;
        frame = tlb_frame[i];
      end
    end
    if (!hit) begin
      if (!pt_valid[page]) begin
        fault          = 1'b1;
        pt_frame[page] = next_frame[7:0];
        pt_valid[page] = 1'b1;
        next_frame     = next_frame + 9'd1;
      end
      frame                = pt_frame[page];
      tlb_tag[fifo_slot]   = page;
      tlb_frame[fifo_slot] = frame;
      tlb_live[fifo_slot]  = 1'b1;
      fifo_slot            = fifo_slot + 4'd1;
    end
    result.physical = {frame, offset};
    result.hit      = hit;
    result.fault    = fault;
    return result;
  endfunction

  function automatic int sender_idle_pct(input phase_t ph);
    case (ph)
      PH_SLOW_RECEIVER: return 28;
      PH_SLOW_SENDER:   return 84;
      default:          return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct(input phase_t ph);
    case (ph)
      PH_SLOW_RECEIVER: return 84;
      PH_SLOW_SENDER:   return 28;
      default:          return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t: MISMATCH %s", $realtime, what);
  endtask

  task automatic add_request(input logic [tlbpt_pkg::VA_W-1:0] va, input phase_t ph);
    request_t r;
    r.address = va;
    r.phase   = ph;
    pending_q.push_back(r);
  endtask

  // Driver: hold the payload until the transfer, then predict it and present the next
  // pending address unless this cycle is picked as a sender gap.
  always @(posedge clk) begin : drive_requests
    bit advance;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      advance = !in_valid;
      if (in_valid && in_ready) begin
        expected_q.push_back(translate_address(in_virtual_address));
        pending_q.delete(0);
        advance = 1'b1;
      end
      if (advance) begin
        if (pending_q.size() > 0 &&
            $urandom_range(0, 99) >= sender_idle_pct(pending_q[0].phase)) begin
          in_valid           <= 1'b1;
          in_virtual_address <= pending_q[0].address;
          active_phase       <= pending_q[0].phase;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transfer must match the oldest prediction field by field.
  // Stall the receiver at random according to the current phase.
  always @(posedge clk) begin : check_results
    translation_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result pa=%h hit=%b fault=%b with nothing expected",
                                  out_phys_addr, out_tlb_hit, out_page_fault));
      end else begin
        want = expected_q.pop_front();
        if (out_phys_addr !== want.physical)
          report_mismatch($sformatf("phys_addr %h, expected %h",
                                    out_phys_addr, want.physical));
        if (out_tlb_hit !== want.hit)
          report_mismatch($sformatf("tlb_hit %b, expected %b (pa %h)",
                                    out_tlb_hit, want.hit, want.physical));
        if (out_page_fault !== want.fault)
          report_mismatch($sformatf("page_fault %b, expected %b (pa %h)",
                                    out_page_fault, want.fault, want.physical));
      end
    end
    out_ready <= rst_n && ($urandom_range(0, 99) >= receiver_idle_pct(active_phase));
  end

  initial begin : run_stimulus
    logic [7:0] hot_page [HOT_PAGES];
    logic [7:0] page;
    int         roll;
    phase_t     ph;

    // Directed: address extremes, a TLB hit on a fresh entry, alternating bit patterns,
    // then enough new pages to wrap the FIFO so page 0 is evicted and comes back as a
    // TLB miss that the page table serves without a fault.
    add_request(16'h0000, PH_SLOW_RECEIVER);
    add_request(16'h00FF, PH_SLOW_RECEIVER);
    add_request(16'hFFFF, PH_SLOW_RECEIVER);
    add_request(16'hFF00, PH_SLOW_RECEIVER);
    add_request(16'hAAAA, PH_SLOW_RECEIVER);
    add_request(16'h5555, PH_SLOW_RECEIVER);
    for (int p = 1; p <= TLB_SLOTS; p++) add_request({8'(p), 8'h3C}, PH_SLOW_RECEIVER);
    add_request(16'h0012, PH_SLOW_RECEIVER);

    // Random: most addresses hit a drifting working set larger than the TLB, so hits,
    // table walks after eviction and fresh faults all keep occurring.
    foreach (hot_page[i]) hot_page[i] = 8'($urandom_range(0, PAGE_TOTAL - 1));
    for (int n = 0; n < 3 * RANDOM_PER_PHASE; n++) begin
      ph   = (n < RANDOM_PER_PHASE) ? PH_SLOW_RECEIVER :
             (n < 2 * RANDOM_PER_PHASE) ? PH_SLOW_SENDER : PH_FREE_RUN;
      roll = $urandom_range(0, 99);
      if (roll < 6)
        hot_page[$urandom_range(0, HOT_PAGES - 1)] = 8'($urandom_range(0, PAGE_TOTAL - 1));
      if (roll < 60) page = hot_page[$urandom_range(0, HOT_PAGES - 1)];
      else page = 8'($urandom_range(0, PAGE_TOTAL - 1));
      add_request({page, 8'($urandom_range(0, 255))}, ph);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every address transferred, then every prediction consumed.
    while (pending_q.size() > 0 || in_valid) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("tlb_page_table_translator_unit test passed");
    end else begin
      $display("tlb_page_table_translator_unit test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run including the page table clear sweep.
  initial begin : watchdog
    #5_000_000;
    $display("tlb_page_table_translator_unit test failed");
    $finish;
  end

endmodule

[tlb_page_table_translator_unit.f]
sv/tlbpt_pkg.sv
sv/tlbpt_ram.sv
sv/tlbpt_cell.sv
sv/tlbpt_page_table_translator_unit.sv
sim/testbench.sv
